>>> hw/rtl/ftwl_pkg.sv
// ----------------------------------------------------------------------------
// ftwl_pkg
// Shared types, constants and the control store of the wear-levelling
// translation block.
// ----------------------------------------------------------------------------
package ftwl_pkg;

    localparam int NUM_BLOCKS_DEF  = 32;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int THR_W     = 16;
    localparam int LB_W      = 5;
    localparam int PHYS_W    = 5;
    localparam int OP_W      = 3;
    localparam int UPC_W     = 5;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    localparam logic [THR_W-1:0] THR_RESET = 16'd5;

    // order matters: the dispatch step jumps to its target plus the action
    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_ERASE = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic [OP_W-1:0] {
        OP_NONE  = 3'd0,
        OP_READ  = 3'd1,
        OP_WRITE = 3'd2,
        OP_ZERO  = 3'd3,
        OP_COPY  = 3'd4
    } disk_op_t;

    typedef enum logic [3:0] {
        C_NEXT,
        C_JUMP,
        C_DISPATCH,
        C_END,
        C_MAP_MISS,
        C_LB_OUT,
        C_NOT_LAST,
        C_NOT_FOUND,
        C_BELOW_THR
    } cond_t;

    typedef enum logic [2:0] {
        E_NOP,
        E_NONE,
        E_UNMAP,
        E_READ,
        E_ZERO,
        E_COPY,
        E_WRITE
    } emit_t;

    typedef enum logic [1:0] {
        SCAN_NONE,
        SCAN_FREE,
        SCAN_USED,
        SCAN_MAP
    } scan_t;

    typedef enum logic [1:0] {
        P_HOLD,
        P_MAP,
        P_BEST
    } psrc_t;

    typedef struct packed {
        cond_t             cond;
        logic [UPC_W-1:0]  target;
        scan_t             scan;
        emit_t             emit;
        logic              last;
        psrc_t             ld_p;
        logic              ld_dest;
        logic              clr_scan;
        logic              unmap_lb;
        logic              cnt_inc;
        logic              free_set;
        logic              free_clr_dest;
        logic              remap;
        logic              commit;
        logic              clear_all;
    } ucw_t;

    typedef struct packed {
        logic map_miss;
        logic lb_out;
        logic not_last;
        logic not_found;
        logic below_thr;
    } seq_stat_t;

    // step addresses
    localparam logic [UPC_W-1:0] ST_LOOKUP   = 5'd0;
    localparam logic [UPC_W-1:0] ST_DISPATCH = 5'd1;
    localparam logic [UPC_W-1:0] ST_J_READ   = 5'd2;
    localparam logic [UPC_W-1:0] ST_J_WRITE  = 5'd3;
    localparam logic [UPC_W-1:0] ST_J_ERASE  = 5'd4;
    localparam logic [UPC_W-1:0] ST_CLEAR    = 5'd5;
    localparam logic [UPC_W-1:0] ST_RD       = 5'd6;
    localparam logic [UPC_W-1:0] ST_RD_HIT   = 5'd7;
    localparam logic [UPC_W-1:0] ST_RD_MISS  = 5'd8;
    localparam logic [UPC_W-1:0] ST_WR       = 5'd9;
    localparam logic [UPC_W-1:0] ST_WR_OLD   = 5'd10;
    localparam logic [UPC_W-1:0] ST_WR_ERASE = 5'd11;
    localparam logic [UPC_W-1:0] ST_SF_INIT  = 5'd12;
    localparam logic [UPC_W-1:0] ST_SF_LOOP  = 5'd13;
    localparam logic [UPC_W-1:0] ST_SF_DRAIN = 5'd14;
    localparam logic [UPC_W-1:0] ST_SF_CHK   = 5'd15;
    localparam logic [UPC_W-1:0] ST_THR      = 5'd16;
    localparam logic [UPC_W-1:0] ST_SU_INIT  = 5'd17;
    localparam logic [UPC_W-1:0] ST_SU_LOOP  = 5'd18;
    localparam logic [UPC_W-1:0] ST_SU_DRAIN = 5'd19;
    localparam logic [UPC_W-1:0] ST_SU_CHK   = 5'd20;
    localparam logic [UPC_W-1:0] ST_COPY     = 5'd21;
    localparam logic [UPC_W-1:0] ST_MS_INIT  = 5'd22;
    localparam logic [UPC_W-1:0] ST_MS_LOOP  = 5'd23;
    localparam logic [UPC_W-1:0] ST_MS_DRAIN = 5'd24;
    localparam logic [UPC_W-1:0] ST_REMAP    = 5'd25;
    localparam logic [UPC_W-1:0] ST_MIG_ZERO = 5'd26;
    localparam logic [UPC_W-1:0] ST_WRITE    = 5'd27;
    localparam logic [UPC_W-1:0] ST_NONE_OK  = 5'd28;
    localparam logic [UPC_W-1:0] ST_ER       = 5'd29;
    localparam logic [UPC_W-1:0] ST_ER_HIT   = 5'd30;

    function automatic ucw_t ucode_rom(input logic [UPC_W-1:0] addr);
        ucw_t w;
        w = '0;
        unique case (addr)
            ST_LOOKUP: begin
                w.cond = C_NEXT;
            end
            ST_DISPATCH: begin
                w.ld_p   = P_MAP;
                w.cond   = C_DISPATCH;
                w.target = ST_J_READ;
            end
            ST_J_READ: begin
                w.cond   = C_JUMP;
                w.target = ST_RD;
            end
            ST_J_WRITE: begin
                w.cond   = C_JUMP;
                w.target = ST_WR;
            end
            ST_J_ERASE: begin
                w.cond   = C_JUMP;
                w.target = ST_ER;
            end
            ST_CLEAR: begin
                w.emit      = E_NONE;
                w.last      = 1'b1;
                w.clear_all = 1'b1;
                w.cond      = C_END;
            end
            ST_RD: begin
                w.cond   = C_MAP_MISS;
                w.target = ST_RD_MISS;
            end
            ST_RD_HIT: begin
                w.emit = E_READ;
                w.last = 1'b1;
                w.cond = C_END;
            end
            ST_RD_MISS: begin
                w.emit = E_UNMAP;
                w.last = 1'b1;
                w.cond = C_END;
            end
            ST_WR: begin
                w.cond   = C_LB_OUT;
                w.target = ST_NONE_OK;
            end
            ST_WR_OLD: begin
                w.cond   = C_MAP_MISS;
                w.target = ST_SF_INIT;
            end
            ST_WR_ERASE: begin
                w.emit     = E_ZERO;
                w.unmap_lb = 1'b1;
                w.cnt_inc  = 1'b1;
                w.free_set = 1'b1;
                w.cond     = C_NEXT;
            end
            ST_SF_INIT: begin
                w.clr_scan = 1'b1;
                w.cond     = C_NEXT;
            end
            ST_SF_LOOP: begin
                w.scan   = SCAN_FREE;
                w.cond   = C_NOT_LAST;
                w.target = ST_SF_LOOP;
            end
            ST_SF_DRAIN: begin
                w.cond = C_NEXT;
            end
            ST_SF_CHK: begin
                w.ld_dest = 1'b1;
                w.ld_p    = P_BEST;
                w.cond    = C_NOT_FOUND;
                w.target  = ST_NONE_OK;
            end
            ST_THR: begin
                w.cond   = C_BELOW_THR;
                w.target = ST_WRITE;
            end
            ST_SU_INIT: begin
                w.clr_scan = 1'b1;
                w.cond     = C_NEXT;
            end
            ST_SU_LOOP: begin
                w.scan   = SCAN_USED;
                w.cond   = C_NOT_LAST;
                w.target = ST_SU_LOOP;
            end
            ST_SU_DRAIN: begin
                w.cond = C_NEXT;
            end
            ST_SU_CHK: begin
                w.cond   = C_NOT_FOUND;
                w.target = ST_WRITE;
            end
            ST_COPY: begin
                w.emit          = E_COPY;
                w.ld_p          = P_BEST;
                w.free_clr_dest = 1'b1;
                w.cond          = C_NEXT;
            end
            ST_MS_INIT: begin
                w.clr_scan = 1'b1;
                w.cond     = C_NEXT;
            end
            ST_MS_LOOP: begin
                w.scan   = SCAN_MAP;
                w.cond   = C_NOT_LAST;
                w.target = ST_MS_LOOP;
            end
            ST_MS_DRAIN: begin
                w.cond = C_NEXT;
            end
            ST_REMAP: begin
                w.remap = 1'b1;
                w.cond  = C_NEXT;
            end
            ST_MIG_ZERO: begin
                w.emit     = E_ZERO;
                w.cnt_inc  = 1'b1;
                w.free_set = 1'b1;
                w.cond     = C_NEXT;
            end
            ST_WRITE: begin
                w.emit   = E_WRITE;
                w.last   = 1'b1;
                w.commit = 1'b1;
                w.cond   = C_END;
            end
            ST_NONE_OK: begin
                w.emit = E_NONE;
                w.last = 1'b1;
                w.cond = C_END;
            end
            ST_ER: begin
                w.cond   = C_MAP_MISS;
                w.target = ST_NONE_OK;
            end
            ST_ER_HIT: begin
                w.emit     = E_ZERO;
                w.last     = 1'b1;
                w.unmap_lb = 1'b1;
                w.cnt_inc  = 1'b1;
                w.free_set = 1'b1;
                w.cond     = C_END;
            end
            default: begin
                w.cond = C_END;
            end
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/flash_translation_wear_leveler.sv
// ----------------------------------------------------------------------------
// flash_translation_wear_leveler
// Logical-to-physical block map with erase counting and wear levelling;
// turns read, write, erase and clear requests into physical disk commands.
// ----------------------------------------------------------------------------
//  channel  | ports                          | payload
//  ---------+--------------------------------+---------------------------------
//  request  | s_axis_tvalid/tready/tdata/tuser | tdata: logical_block; tuser: action
//  result   | m_axis_tvalid/tready/tdata/tuser/tlast | tdata: disk_op, phys_block,
//           |                                |   copy_dest; tuser: status
//  config   | cfg_valid/cfg_ready/cfg_data   | wear_threshold
//
//  a write sweeps the count memory for a free block, and with a migration the
//  count memory again and then the map memory, each through one read port,
//  one entry a cycle.
//  aresetn (synchronous) empties the map, zeroes the counts and frees all
//  blocks at once through per-entry valid bits; no clearing pass.
//  a result waiting on m_axis_tready holds the sequencer only when the next
//  result is due; a new request is taken once the last result is registered.
// ----------------------------------------------------------------------------
module flash_translation_wear_leveler #(
    parameter int NUM_BLOCKS  = ftwl_pkg::NUM_BLOCKS_DEF,
    parameter int COUNT_WIDTH = ftwl_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ftwl_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // logical_block[4:0], zero pad
    input  logic [1:0]                      s_axis_tuser,  // action[1:0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ftwl_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // disk_op[2:0], phys_block[7:3],
                                                           // copy_dest[12:8], zero pad
    output logic [0:0]                      m_axis_tuser,  // status[0]
    output logic                            m_axis_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ftwl_pkg::THR_W-1:0]      cfg_data
);
    import ftwl_pkg::*;

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_BLOCKS - 1);

    // sequencer
    ucw_t      cw;
    seq_stat_t stat;
    logic      busy, stall, adv, start;

    // request and threshold
    logic [LB_W-1:0]  lb_reg;
    action_t          act_reg;
    logic [THR_W-1:0] thr_reg;
    logic [IDX_W-1:0] lb_idx;
    logic             lb_out;

    // tables
    logic [COUNT_WIDTH-1:0] cnt_mem [NUM_BLOCKS];
    logic [IDX_W-1:0]       map_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0]  cvalid_reg, cvalid_next;
    logic [NUM_BLOCKS-1:0]  mvalid_reg, mvalid_next;
    logic [NUM_BLOCKS-1:0]  free_reg, free_next;
    logic [COUNT_WIDTH-1:0] cnt_rd_reg;
    logic                   cvalid_rd_reg;
    logic [IDX_W-1:0]       map_rd_reg;
    logic                   mvalid_rd_reg;
    logic [IDX_W-1:0]       cnt_ra, map_ra, map_wa;
    logic                   cnt_we, map_we;
    logic [IDX_W-1:0]       map_wd;
    logic [COUNT_WIDTH-1:0] cnt_eff, cnt_inc_val;

    // datapath registers
    logic [IDX_W-1:0]       p_reg, p_next;
    logic [IDX_W-1:0]       dest_reg, dest_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       best_reg, best_next;
    logic [COUNT_WIDTH-1:0] best_cnt_reg, best_cnt_next;
    logic                   found_reg, found_next;
    scan_t                  cmp_mode_reg, cmp_mode_next;
    logic [IDX_W-1:0]       cmp_idx_reg;
    logic                   scanning;

    // result register
    logic                   m_valid_reg, m_valid_next;
    disk_op_t               m_op_reg, m_op_next;
    logic [PHYS_W-1:0]      m_phys_reg, m_phys_next;
    logic [PHYS_W-1:0]      m_dest_reg, m_dest_next;
    logic                   m_status_reg, m_status_next;
    logic                   m_last_reg;
    logic                   out_load;

    ftwl_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .act     (act_reg),
        .stat    (stat),
        .stall   (stall),
        .busy    (busy),
        .cw      (cw)
    );

    assign s_axis_tready = !busy;
    assign start         = s_axis_tvalid && !busy;
    assign cfg_ready     = 1'b1;

    assign stall    = busy && (cw.emit != E_NOP) && m_valid_reg && !m_axis_tready;
    assign adv      = busy && !stall;
    assign out_load = adv && (cw.emit != E_NOP);
    assign scanning = (cw.scan != SCAN_NONE);

    assign lb_idx = IDX_W'(lb_reg);
    assign lb_out = (32'(lb_reg) >= 32'(NUM_BLOCKS));

    assign cnt_ra = scanning ? idx_reg : p_reg;
    assign map_ra = scanning ? idx_reg : lb_idx;

    assign cnt_eff     = cvalid_rd_reg ? cnt_rd_reg : '0;
    // saturating erase count
    assign cnt_inc_val = (cnt_eff == '1) ? cnt_eff : cnt_eff + COUNT_WIDTH'(1);
    assign cnt_we      = adv && cw.cnt_inc;

    assign map_we = adv && (cw.commit || (cw.remap && found_reg));
    assign map_wa = cw.remap ? best_reg : lb_idx;
    assign map_wd = cw.remap ? dest_reg : p_reg;

    always_comb begin
        stat.map_miss  = lb_out || !mvalid_rd_reg;
        stat.lb_out    = lb_out;
        stat.not_last  = (idx_reg != IDX_LAST);
        stat.not_found = !found_reg;
        stat.below_thr = (CMP_W'(best_cnt_reg) < CMP_W'(thr_reg));
    end

    // tables: memories with registered reads
    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[p_reg] <= cnt_inc_val;
        end
        cnt_rd_reg <= cnt_mem[cnt_ra];
    end

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        map_rd_reg <= map_mem[map_ra];
    end

    always_comb begin
        cvalid_next = cvalid_reg;
        mvalid_next = mvalid_reg;
        free_next   = free_reg;
        if (adv) begin
            if (cw.clear_all) begin
                cvalid_next = '0;
                mvalid_next = '0;
                free_next   = '1;
            end
            if (cw.cnt_inc) begin
                cvalid_next[p_reg] = 1'b1;
            end
            if (cw.unmap_lb) begin
                mvalid_next[lb_idx] = 1'b0;
            end
            if (cw.free_set) begin
                free_next[p_reg] = 1'b1;
            end
            if (cw.free_clr_dest) begin
                free_next[dest_reg] = 1'b0;
            end
            if (cw.commit) begin
                free_next[p_reg]    = 1'b0;
                mvalid_next[lb_idx] = 1'b1;
            end
        end
    end

    // scan compare stage, working on the element read in the previous cycle
    always_comb begin
        idx_next      = idx_reg;
        best_next     = best_reg;
        best_cnt_next = best_cnt_reg;
        found_next    = found_reg;
        cmp_mode_next = SCAN_NONE;
        if (adv && cw.clr_scan) begin
            idx_next   = '0;
            found_next = 1'b0;
        end else begin
            if (adv && scanning) begin
                idx_next      = idx_reg + 1'b1;
                cmp_mode_next = cw.scan;
            end
            case (cmp_mode_reg)
                SCAN_FREE, SCAN_USED: begin
                    if ((free_reg[cmp_idx_reg] == (cmp_mode_reg == SCAN_FREE)) &&
                        (!found_reg || (cnt_eff < best_cnt_reg))) begin
                        best_next     = cmp_idx_reg;
                        best_cnt_next = cnt_eff;
                        found_next    = 1'b1;
                    end
                end
                SCAN_MAP: begin
                    // first logical entry pointing at the migration source
                    if (!found_reg && mvalid_rd_reg && (map_rd_reg == p_reg)) begin
                        best_next  = cmp_idx_reg;
                        found_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        p_next    = p_reg;
        dest_next = dest_reg;
        if (adv) begin
            case (cw.ld_p)
                P_MAP:   p_next = map_rd_reg;
                P_BEST:  p_next = best_reg;
                default: ;
            endcase
            if (cw.ld_dest) begin
                dest_next = best_reg;
            end
        end
    end

    always_comb begin
        m_op_next     = OP_NONE;
        m_phys_next   = '0;
        m_dest_next   = '0;
        m_status_next = 1'b0;
        unique case (cw.emit)
            E_UNMAP: m_status_next = 1'b1;
            E_READ: begin
                m_op_next   = OP_READ;
                m_phys_next = PHYS_W'(p_reg);
            end
            E_ZERO: begin
                m_op_next   = OP_ZERO;
                m_phys_next = PHYS_W'(p_reg);
            end
            E_COPY: begin
                m_op_next   = OP_COPY;
                m_phys_next = PHYS_W'(best_reg);
                m_dest_next = PHYS_W'(dest_reg);
            end
            E_WRITE: begin
                m_op_next   = OP_WRITE;
                m_phys_next = PHYS_W'(p_reg);
            end
            default: ;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg      <= THR_RESET;
            cvalid_reg   <= '0;
            mvalid_reg   <= '0;
            free_reg     <= '1;
            found_reg    <= 1'b0;
            cmp_mode_reg <= SCAN_NONE;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                thr_reg <= cfg_data;
            end
            cvalid_reg   <= cvalid_next;
            mvalid_reg   <= mvalid_next;
            free_reg     <= free_next;
            found_reg    <= found_next;
            cmp_mode_reg <= cmp_mode_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            lb_reg  <= s_axis_tdata[LB_W-1:0];
            act_reg <= action_t'(s_axis_tuser);
        end
        cvalid_rd_reg <= cvalid_reg[cnt_ra];
        mvalid_rd_reg <= mvalid_reg[map_ra];
        idx_reg       <= idx_next;
        cmp_idx_reg   <= idx_reg;
        best_reg      <= best_next;
        best_cnt_reg  <= best_cnt_next;
        p_reg         <= p_next;
        dest_reg      <= dest_next;
        if (out_load) begin
            m_op_reg     <= m_op_next;
            m_phys_reg   <= m_phys_next;
            m_dest_reg   <= m_dest_next;
            m_status_reg <= m_status_next;
            m_last_reg   <= cw.last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, m_dest_reg, m_phys_reg, m_op_reg};
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tlast  = m_last_reg;

`ifndef NO_ASSERTIONS
    // an accepted request makes the block busy, so s_axis_tready drops after the accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while previous one still in work");

    // unmapped status only ever comes with no disk command
    a_status_no_op: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata[2:0] == OP_NONE))
        else $error("unmapped status with a disk command");

    // copy destination is zero except on a copy
    a_dest_only_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[2:0] != OP_COPY) |-> (m_axis_tdata[12:8] == '0))
        else $error("copy destination set on a non-copy command");

    // every scan has drained its compare stage before the next request
    a_idle_no_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy |-> (cmp_mode_reg == SCAN_NONE))
        else $error("compare stage active while idle");
`endif

endmodule

>>> hw/rtl/ftwl_seq.sv
// ----------------------------------------------------------------------------
// ftwl_seq
// Step counter and control store: one control word per step, with
// conditional jumps, a dispatch on the request action and a stall hold.
// ----------------------------------------------------------------------------
module ftwl_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  ftwl_pkg::action_t   act,
    input  ftwl_pkg::seq_stat_t stat,
    input  logic                stall,
    output logic                busy,
    output ftwl_pkg::ucw_t      cw
);
    import ftwl_pkg::*;

    logic [UPC_W-1:0] upc_reg, upc_next;
    logic             busy_reg, busy_next;
    logic             taken;

    assign cw   = ucode_rom(upc_reg);
    assign busy = busy_reg;

    always_comb begin
        unique case (cw.cond)
            C_MAP_MISS:  taken = stat.map_miss;
            C_LB_OUT:    taken = stat.lb_out;
            C_NOT_LAST:  taken = stat.not_last;
            C_NOT_FOUND: taken = stat.not_found;
            C_BELOW_THR: taken = stat.below_thr;
            C_JUMP:      taken = 1'b1;
            default:     taken = 1'b0;
        endcase
    end

    always_comb begin
        upc_next  = upc_reg;
        busy_next = busy_reg;
        if (!busy_reg) begin
            if (start) begin
                upc_next  = ST_LOOKUP;
                busy_next = 1'b1;
            end
        end else if (!stall) begin
            unique case (cw.cond)
                C_END:      busy_next = 1'b0;
                C_DISPATCH: upc_next  = cw.target + UPC_W'(act);
                default:    upc_next  = taken ? cw.target : upc_reg + 1'b1;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg  <= ST_LOOKUP;
            busy_reg <= 1'b0;
        end else begin
            upc_reg  <= upc_next;
            busy_reg <= busy_next;
        end
    end

endmodule

>>> bench/tb_flash_translation_wear_leveler.sv
// ----------------------------------------------------------------------------
// tb_flash_translation_wear_leveler
// Self-checking bench for the wear-levelling translation block. Requests are
// streamed in with random gaps, and the command stream is taken with random
// back-pressure. A behavioural copy of the map, erase counts and free flags
// predicts every disk command, which is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_flash_translation_wear_leveler;

    timeunit 1ns;
    timeprecision 1ps;

    import ftwl_pkg::*;

    localparam int NBLK = 32;

    typedef struct packed {
        disk_op_t          op;
        logic [PHYS_W-1:0] phys;
        logic [PHYS_W-1:0] dest;
        logic              status;
        logic              last;
    } disk_cmd_t;

    typedef struct packed {
        action_t         act;
        logic [LB_W-1:0] lb;
    } request_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [1:0]           s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]           m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [THR_W-1:0]     cfg_data      = '0;

    // shadow of the block's tables
    bit                map_ok   [NBLK];
    logic [PHYS_W-1:0] map_phys [NBLK];
    logic [15:0]       wear     [NBLK];
    bit                is_free  [NBLK];
    logic [THR_W-1:0]  thr_model;

    request_t  req_pending[$];
    disk_cmd_t cmd_expected[$];
    request_t  req_driven;
    int        n_queued   = 0;
    int        n_accepted = 0;
    int        in_gap     = 0;
    int        out_stall  = 0;
    int        errors     = 0;
    bit        calm       = 1'b0;

    flash_translation_wear_leveler i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // command predictor
    // ------------------------------------------------------------------
    function automatic void wipe_tables();
        for (int i = 0; i < NBLK; i++) begin
            map_ok[i]   = 1'b0;
            map_phys[i] = '0;
            wear[i]     = '0;
            is_free[i]  = 1'b1;
        end
    endfunction

    function automatic void push_cmd(disk_op_t op, int phys, int dest, bit st);
        disk_cmd_t c;
        c.op     = op;
        c.phys   = phys[PHYS_W-1:0];
        c.dest   = dest[PHYS_W-1:0];
        c.status = st;
        c.last   = 1'b0;
        cmd_expected.push_back(c);
    endfunction

    function automatic void zero_block(int p);
        push_cmd(OP_ZERO, p, 0, 1'b0);
        if (wear[p] != 16'hffff)
            wear[p] = wear[p] + 16'd1;
        is_free[p] = 1'b1;
    endfunction

    // least worn block whose free flag matches, lowest index on a tie
    function automatic int least_worn(bit want_free);
        int best;
        best = -1;
        for (int i = 0; i < NBLK; i++)
            if (is_free[i] == want_free && (best < 0 || wear[i] < wear[best]))
                best = i;
        return best;
    endfunction

    function automatic void place_write(int lb);
        int  dest;
        int  src;
        int  target;
        bit  moved;
        if (map_ok[lb]) begin
            zero_block(map_phys[lb]);
            map_ok[lb] = 1'b0;
        end
        dest = least_worn(1'b1);
        if (dest < 0) begin
            push_cmd(OP_NONE, 0, 0, 1'b0);
            return;
        end
        target = dest;
        if (wear[dest] >= thr_model) begin
            src = least_worn(1'b0);
            if (src >= 0) begin
                push_cmd(OP_COPY, src, dest, 1'b0);
                is_free[dest] = 1'b0;
                moved = 1'b0;
                for (int i = 0; i < NBLK; i++)
                    if (!moved && map_ok[i] && map_phys[i] == src[PHYS_W-1:0]) begin
                        map_phys[i] = dest[PHYS_W-1:0];
                        moved = 1'b1;
                    end
                zero_block(src);
                target = src;
            end
        end
        push_cmd(OP_WRITE, target, 0, 1'b0);
        is_free[target] = 1'b0;
        map_ok[lb]      = 1'b1;
        map_phys[lb]    = target[PHYS_W-1:0];
    endfunction

    function automatic void translate_request(request_t rq);
        disk_cmd_t c;
        int        lb;
        lb = rq.lb;
        case (rq.act)
            ACT_READ: begin
                if (map_ok[lb])
                    push_cmd(OP_READ, map_phys[lb], 0, 1'b0);
                else
                    push_cmd(OP_NONE, 0, 0, 1'b1);
            end
            ACT_WRITE: begin
                place_write(lb);
            end
            ACT_ERASE: begin
                if (map_ok[lb]) begin
                    zero_block(map_phys[lb]);
                    map_ok[lb] = 1'b0;
                end else begin
                    push_cmd(OP_NONE, 0, 0, 1'b0);
                end
            end
            default: begin
                wipe_tables();
                push_cmd(OP_NONE, 0, 0, 1'b0);
            end
        endcase
        c      = cmd_expected.pop_back();
        c.last = 1'b1;
        cmd_expected.push_back(c);
    endfunction

    // half back to back, some short pauses, the odd long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 90);
    endfunction

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                translate_request(req_driven);
                n_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (req_pending.size() != 0) begin
                    req_driven    = req_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(S_TDATA_W-LB_W){1'b0}}, req_driven.lb};
                    s_axis_tuser  <= req_driven.act;
                    in_gap = calm ? 0 : pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // command monitor
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        disk_cmd_t want;
        disk_cmd_t got;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.op     = disk_op_t'(m_axis_tdata[2:0]);
                got.phys   = m_axis_tdata[7:3];
                got.dest   = m_axis_tdata[12:8];
                got.status = m_axis_tuser[0];
                got.last   = m_axis_tlast;
                if (cmd_expected.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected command: op %0d phys %0d dest %0d st %0d last %0d",
                                 got.op, got.phys, got.dest, got.status, got.last);
                end else begin
                    want = cmd_expected.pop_front();
                    if (got != want) begin
                        errors++;
                        if (errors <= 10)
                            $display({"command mismatch: exp op %0d phys %0d dest %0d st %0d ",
                                      "last %0d, got op %0d phys %0d dest %0d st %0d last %0d"},
                                     want.op, want.phys, want.dest, want.status, want.last,
                                     got.op, got.phys, got.dest, got.status, got.last);
                    end
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 25)
                    out_stall = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic queue_req(action_t act, int lb);
        request_t rq;
        rq.act = act;
        rq.lb  = lb[LB_W-1:0];
        req_pending.push_back(rq);
        n_queued++;
    endtask

    // writes dominate so that wear builds up; a hot set of logical blocks
    // concentrates erases, clears stay rare
    task automatic queue_random(int count);
        int r;
        int lb;
        for (int k = 0; k < count; k++) begin
            r  = $urandom_range(0, 99);
            lb = ($urandom_range(0, 9) < 4) ? $urandom_range(0, 31) : $urandom_range(0, 7);
            if (r < 55)
                queue_req(ACT_WRITE, lb);
            else if (r < 75)
                queue_req(ACT_READ, lb);
            else if (r < 97)
                queue_req(ACT_ERASE, lb);
            else
                queue_req(ACT_CLEAR, lb);
        end
    endtask

    task automatic settle();
        while (n_accepted != n_queued || cmd_expected.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_threshold(logic [THR_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        thr_model = value;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        wipe_tables();
        thr_model = THR_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset threshold: misses, remapping writes, erase, clear
        queue_req(ACT_READ, 0);
        queue_req(ACT_ERASE, 31);
        queue_req(ACT_WRITE, 0);
        queue_req(ACT_READ, 0);
        queue_req(ACT_WRITE, 31);
        queue_req(ACT_WRITE, 0);
        queue_req(ACT_READ, 31);
        queue_req(ACT_ERASE, 31);
        queue_req(ACT_READ, 31);
        queue_req(ACT_CLEAR, 0);
        queue_req(ACT_READ, 0);
        settle();

        // zero threshold: every write wants to migrate, skipped when nothing is in use
        set_threshold(16'd0);
        queue_req(ACT_WRITE, 10);
        queue_req(ACT_WRITE, 21);
        queue_req(ACT_READ, 10);
        queue_req(ACT_READ, 21);
        queue_req(ACT_WRITE, 10);
        queue_req(ACT_ERASE, 21);
        queue_req(ACT_WRITE, 21);
        queue_req(ACT_CLEAR, 31);
        queue_req(ACT_WRITE, 3);
        queue_req(ACT_WRITE, 3);
        queue_random(50);

        set_threshold(16'hffff);
        queue_random(60);

        set_threshold(16'd1);
        queue_random(100);

        set_threshold(16'($urandom_range(2, 9)));
        settle();
        calm = 1'b1;
        queue_random(110);
        settle();
        calm = 1'b0;

        set_threshold(16'd3);
        queue_random(150);

        settle();
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

endmodule
